// ----- rtl/typed_packet_deframer_xor_check_macros.svh -----
// Assertion macros for the typed packet deframer.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef TYPED_PACKET_DEFRAMER_XOR_CHECK_MACROS_SVH
`define TYPED_PACKET_DEFRAMER_XOR_CHECK_MACROS_SVH

// Same-cycle implication.
`define TPDX_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tpdx assertion failed");

// Next-cycle implication.
`define TPDX_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tpdx assertion failed");

`endif

// ----- rtl/tpdx_pkg.sv -----
// Shared types, codes and the length lookup for the typed packet deframer.
// No dependencies.
`timescale 1ns / 1ps

package tpdx_pkg;

    localparam int NUM_TYPES = 16;
    localparam logic [8:0] TYPE_LIMIT = 9'(NUM_TYPES);

    // parse status codes
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_DONE  = 2'd1;
    localparam logic [1:0] ST_ERR   = 2'd2;

    // operation codes
    localparam logic OP_START = 1'b0;
    localparam logic OP_DATA  = 1'b1;

    // configuration register indexes
    localparam logic [2:0] CFG_LOWEST_TYPE  = 3'd0;
    localparam logic [2:0] CFG_HIGHEST_TYPE = 3'd1;
    localparam logic [2:0] CFG_BIG_THRESH   = 3'd2;
    localparam logic [2:0] CFG_LENGTHS_LOW  = 3'd3;
    localparam logic [2:0] CFG_LENGTHS_HIGH = 3'd4;

    typedef struct packed {
        logic [3:0]  lowest_type;
        logic [3:0]  highest_type;
        logic [7:0]  big_threshold;
        logic [63:0] lengths_low;
        logic [63:0] lengths_high;
    } cfg_t;

    typedef struct packed {
        logic [1:0] parse_status;
        logic       payload_valid;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [3:0] current_type;
        logic       packet_done;
    } result_t;

    function automatic logic [7:0] length_of(input cfg_t cfg, input logic [3:0] t);
        logic [63:0] word;
        word = t[3] ? cfg.lengths_high : cfg.lengths_low;
        return word[{t[2:0], 3'b000} +: 8];
    endfunction

endpackage

// ----- rtl/tpdx_cfg_regs.sv -----
// Configuration register file of the typed packet deframer.
// Depends on tpdx_pkg.
`timescale 1ns / 1ps

module tpdx_cfg_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [63:0]         cfg_data,
    output tpdx_pkg::cfg_t      cfg
);

    tpdx_pkg::cfg_t cfg_reg;
    tpdx_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                tpdx_pkg::CFG_LOWEST_TYPE:  cfg_next.lowest_type   = cfg_data[3:0];
                tpdx_pkg::CFG_HIGHEST_TYPE: cfg_next.highest_type  = cfg_data[3:0];
                tpdx_pkg::CFG_BIG_THRESH:   cfg_next.big_threshold = cfg_data[7:0];
                tpdx_pkg::CFG_LENGTHS_LOW:  cfg_next.lengths_low   = cfg_data;
                tpdx_pkg::CFG_LENGTHS_HIGH: cfg_next.lengths_high  = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lowest_type   <= 4'd1;
            cfg_reg.highest_type  <= 4'd15;
            cfg_reg.big_threshold <= 8'd32;
            cfg_reg.lengths_low   <= 64'd0;
            cfg_reg.lengths_high  <= 64'd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/tpdx_parser.sv -----
// Packet parser state and the per-beat update logic of the deframer.
// Depends on tpdx_pkg and typed_packet_deframer_xor_check_macros.svh.
`timescale 1ns / 1ps
`include "typed_packet_deframer_xor_check_macros.svh"

module tpdx_parser
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  logic                 op,
    input  logic [7:0]           rx_data,
    input  tpdx_pkg::cfg_t       cfg,
    output tpdx_pkg::result_t    result
);

    logic [1:0] status_reg,    status_next;
    logic [3:0] type_reg,      type_next;
    logic [8:0] bytes_left_reg, bytes_left_next;
    logic [7:0] xor_reg,       xor_next;
    logic [7:0] position_reg,  position_next;
    logic       big_reg,       big_next;
    logic       recv_reg,      recv_next;

    logic       type_bad;
    logic [8:0] new_left;
    logic [8:0] left_dec;

    assign type_bad = (rx_data == 8'd0)
                   || ({1'b0, rx_data} >= tpdx_pkg::TYPE_LIMIT)
                   || (rx_data < {4'd0, cfg.lowest_type})
                   || (rx_data > {4'd0, cfg.highest_type});
    assign new_left = {1'b0, tpdx_pkg::length_of(cfg, rx_data[3:0])} + 9'd1;
    assign left_dec = bytes_left_reg - 9'd1;

    always_comb
    begin
        status_next     = status_reg;
        type_next       = type_reg;
        bytes_left_next = bytes_left_reg;
        xor_next        = xor_reg;
        position_next   = position_reg;
        big_next        = big_reg;
        recv_next       = recv_reg;
        result.payload_valid = 1'b0;
        result.payload_byte  = 8'd0;
        result.payload_index = 8'd0;
        result.packet_done   = 1'b0;

        if (op == tpdx_pkg::OP_START)
        begin
            recv_next = 1'b1;
            // a big packet spans two transfers: only drop the mark
            if (big_reg)
            begin
                big_next = 1'b0;
            end
            else
            begin
                status_next     = tpdx_pkg::ST_EMPTY;
                type_next       = 4'd0;
                bytes_left_next = 9'd0;
                xor_next        = 8'd0;
                position_next   = 8'd0;
            end
        end
        else if (recv_reg)
        begin
            priority if (status_reg == tpdx_pkg::ST_DONE || status_reg == tpdx_pkg::ST_ERR)
            begin
                status_next = tpdx_pkg::ST_ERR;
            end
            else if (type_reg == 4'd0)
            begin
                if (type_bad)
                begin
                    status_next = tpdx_pkg::ST_ERR;
                end
                else
                begin
                    type_next       = rx_data[3:0];
                    bytes_left_next = new_left;
                    xor_next        = {4'd0, rx_data[3:0]};
                    position_next   = 8'd0;
                    if (new_left > {1'b0, cfg.big_threshold})
                    begin
                        big_next = 1'b1;
                    end
                end
            end
            else if (bytes_left_reg != 9'd0)
            begin
                bytes_left_next = left_dec;
                if (left_dec != 9'd0)
                begin
                    result.payload_valid = 1'b1;
                    result.payload_byte  = rx_data;
                    result.payload_index = position_reg;
                    xor_next             = xor_reg ^ rx_data;
                    position_next        = position_reg + 8'd1;
                end
                else
                begin
                    result.packet_done = 1'b1;
                    status_next = (xor_reg == rx_data) ? tpdx_pkg::ST_DONE : tpdx_pkg::ST_ERR;
                end
            end
        end

        result.parse_status = status_next;
        result.current_type = type_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg     <= tpdx_pkg::ST_EMPTY;
            type_reg       <= 4'd0;
            bytes_left_reg <= 9'd0;
            xor_reg        <= 8'd0;
            position_reg   <= 8'd0;
            big_reg        <= 1'b0;
            recv_reg       <= 1'b0;
        end
        else if (fire)
        begin
            status_reg     <= status_next;
            type_reg       <= type_next;
            bytes_left_reg <= bytes_left_next;
            xor_reg        <= xor_next;
            position_reg   <= position_next;
            big_reg        <= big_next;
            recv_reg       <= recv_next;
        end
    end

    `TPDX_ASSERT_NOW(a_done_no_left, status_reg == tpdx_pkg::ST_DONE, bytes_left_reg == 9'd0)
    `TPDX_ASSERT_NOW(a_big_has_type, big_reg, type_reg != 4'd0)
    `TPDX_ASSERT_NOW(a_done_final, fire && result.packet_done,
        result.parse_status == tpdx_pkg::ST_DONE || result.parse_status == tpdx_pkg::ST_ERR)
    `TPDX_ASSERT_NEXT(a_index_advance, fire && result.payload_valid,
        position_reg == $past(position_reg) + 8'd1)

endmodule

// ----- rtl/typed_packet_deframer_xor_check.sv -----
// Top level: one beat in per cycle unless in_stall; beats and results are registered.
// A stalled output holds its result while the input register still takes one more beat.
// Throughput: one beat per cycle unless stalled, set by the single-pass parser update.
// Reset (rst_n low, asynchronous) empties both registers, clears the parser state and
// returns the configuration to its defaults.
`timescale 1ns / 1ps

module typed_packet_deframer_xor_check
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        operation,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  parse_status,
    output logic        payload_valid,
    output logic [7:0]  payload_byte,
    output logic [7:0]  payload_index,
    output logic [3:0]  current_type,
    output logic        packet_done
);

    tpdx_pkg::cfg_t    cfg;
    tpdx_pkg::result_t res_next;
    tpdx_pkg::result_t res_reg;

    logic       in_valid_reg;
    logic       op_reg;
    logic [7:0] byte_reg;
    logic       out_valid_reg;
    logic       fire;

    // advance the held beat when the result register is free or draining
    assign fire     = in_valid_reg && !(out_valid_reg && out_stall);
    assign in_stall = in_valid_reg && out_valid_reg && out_stall;

    tpdx_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpdx_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .fire    (fire),
        .op      (op_reg),
        .rx_data (byte_reg),
        .cfg     (cfg),
        .result  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg   <= operation;
            byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign parse_status  = res_reg.parse_status;
    assign payload_valid = res_reg.payload_valid;
    assign payload_byte  = res_reg.payload_byte;
    assign payload_index = res_reg.payload_index;
    assign current_type  = res_reg.current_type;
    assign packet_done   = res_reg.packet_done;

endmodule

// ----- dv/tb_typed_packet_deframer_xor_check.sv -----
// Self-checking testbench for typed_packet_deframer_xor_check: a directed table, then random
// packets under several register settings, checked against an in-bench parser model.
// Depends on tpdx_pkg and the deframer RTL only.
`timescale 1ns / 1ps

module tb_typed_packet_deframer_xor_check;

    import tpdx_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BEATS = 1100;
    localparam int PHASE_BEATS  = 150;
    localparam int HOLD_CYCLES  = 64;
    localparam int IDLE_PCT     = 24;

    typedef enum logic {ROW_BEAT, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t   kind;
        logic        op;
        logic [7:0]  data;
        logic [2:0]  idx;
        logic [63:0] val;
        bit          pinned;
        result_t     want;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        operation;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  parse_status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [3:0]  current_type;
    logic        packet_done;

    // parser model state and its copy of the registers
    cfg_t        cfg_m;
    logic [1:0]  pkt_status;
    logic [3:0]  pkt_type;
    logic [8:0]  bytes_to_go;
    logic [7:0]  xor_acc;
    logic [7:0]  pay_pos;
    logic        big_pending;
    logic        in_transfer;

    result_t     parse_results_due[$];
    stim_row_t   directed_rows[$];
    int          beats_sent = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;
    bit          hold_pending = 1'b0;

    typed_packet_deframer_xor_check dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic result_t parse_beat(logic op, logic [7:0] b);
        result_t      r;
        logic [127:0] len_table;
        r = '0;
        len_table = {cfg_m.lengths_high, cfg_m.lengths_low};
        if (op == OP_START)
        begin
            in_transfer = 1'b1;
            if (big_pending)
                big_pending = 1'b0;
            else
            begin
                pkt_status = ST_EMPTY;
                pkt_type = '0;
                bytes_to_go = '0;
                xor_acc = '0;
                pay_pos = '0;
            end
        end
        else if (in_transfer)
        begin
            if (pkt_status == ST_DONE || pkt_status == ST_ERR)
                pkt_status = ST_ERR;
            else if (pkt_type == 4'd0)
            begin
                if (b == 8'd0 || b >= NUM_TYPES || b < cfg_m.lowest_type
                    || b > cfg_m.highest_type)
                    pkt_status = ST_ERR;
                else
                begin
                    pkt_type = b[3:0];
                    bytes_to_go = {1'b0, len_table[{b[3:0], 3'b000} +: 8]} + 9'd1;
                    xor_acc = b;
                    pay_pos = '0;
                    if (bytes_to_go > {1'b0, cfg_m.big_threshold})
                        big_pending = 1'b1;
                end
            end
            else if (bytes_to_go != 9'd0)
            begin
                bytes_to_go = bytes_to_go - 9'd1;
                if (bytes_to_go != 9'd0)
                begin
                    r.payload_valid = 1'b1;
                    r.payload_byte = b;
                    r.payload_index = pay_pos;
                    xor_acc = xor_acc ^ b;
                    pay_pos = pay_pos + 8'd1;
                end
                else
                begin
                    r.packet_done = 1'b1;
                    pkt_status = (xor_acc == b) ? ST_DONE : ST_ERR;
                end
            end
        end
        r.parse_status = pkt_status;
        r.current_type = pkt_type;
        return r;
    endfunction

    task automatic send_beat(logic op, logic [7:0] b, bit pinned, result_t want);
        result_t r;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        rx_byte <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        r = parse_beat(op, b);
        parse_results_due.push_back(pinned ? want : r);
        beats_sent++;
    endtask

    task automatic send_noise(int n);
        repeat (n)
            send_beat(1'($urandom_range(0, 1)), 8'($urandom), 1'b0, '0);
    endtask

    // One transfer: start, type byte, payload, checksum; if the type byte opens no fresh packet, noise
    // follows instead. Big packets usually get a second start somewhere inside, as a split transfer would.
    task automatic send_packet();
        logic [7:0] ty;
        logic [7:0] csum;
        int         split;
        int         sent;
        send_beat(OP_START, 8'($urandom), 1'b0, '0);
        if (cfg_m.lowest_type <= cfg_m.highest_type && $urandom_range(0, 9) != 0)
            ty = 8'($urandom_range(cfg_m.highest_type, cfg_m.lowest_type));
        else
            ty = 8'($urandom_range(0, 255));
        send_beat(OP_DATA, ty, 1'b0, '0);
        if (pkt_type == 4'd0 || pkt_status != ST_EMPTY)
        begin
            send_noise($urandom_range(0, 3));
            return;
        end
        split = -1;
        if (big_pending && $urandom_range(0, 99) < 85)
            split = $urandom_range(0, bytes_to_go - 1);
        sent = 0;
        while (bytes_to_go > 9'd1)
        begin
            if (sent == split)
                send_beat(OP_START, 8'($urandom), 1'b0, '0);
            send_beat(OP_DATA, 8'($urandom), 1'b0, '0);
            sent++;
        end
        if (sent == split)
            send_beat(OP_START, 8'($urandom), 1'b0, '0);
        csum = xor_acc;
        if ($urandom_range(0, 99) < 12)
            csum = csum ^ 8'($urandom_range(1, 255));
        send_beat(OP_DATA, csum, 1'b0, '0);
        if ($urandom_range(0, 9) == 0)
            send_noise($urandom_range(1, 3));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (parse_results_due.size() != 0)
            @(posedge clk);
    endtask

    // Leaves cfg_we high; the caller drops it after the last write of a batch.
    task automatic write_reg(logic [2:0] idx, logic [63:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_LOWEST_TYPE:  cfg_m.lowest_type = val[3:0];
            CFG_HIGHEST_TYPE: cfg_m.highest_type = val[3:0];
            CFG_BIG_THRESH:   cfg_m.big_threshold = val[7:0];
            CFG_LENGTHS_LOW:  cfg_m.lengths_low = val;
            CFG_LENGTHS_HIGH: cfg_m.lengths_high = val;
            default: ;
        endcase
    endtask

    task automatic add_beat(logic op, logic [7:0] b, bit pinned, logic [1:0] st,
                            logic [3:0] ty, logic done);
        stim_row_t row;
        row = '{kind: ROW_BEAT, op: op, data: b, idx: '0, val: '0, pinned: pinned,
                want: '0};
        row.want.parse_status = st;
        row.want.current_type = ty;
        row.want.packet_done = done;
        directed_rows.push_back(row);
    endtask

    task automatic add_write(logic [2:0] idx, logic [63:0] val);
        stim_row_t row;
        row = '{kind: ROW_WRITE, op: OP_START, data: '0, idx: idx, val: val,
                pinned: 1'b0, want: '0};
        directed_rows.push_back(row);
    endtask

    task automatic report(string name, int unsigned want, int unsigned got);
        mismatches++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    endtask

    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = {parse_status, payload_valid, payload_byte, payload_index,
                   current_type, packet_done};
            if (parse_results_due.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result beat, expected none, got %h", $time, got);
            end
            else
            begin
                want = parse_results_due.pop_front();
                if (got.parse_status !== want.parse_status)
                    report("parse_status", want.parse_status, got.parse_status);
                if (got.payload_valid !== want.payload_valid)
                    report("payload_valid", want.payload_valid, got.payload_valid);
                if (got.payload_byte !== want.payload_byte)
                    report("payload_byte", want.payload_byte, got.payload_byte);
                if (got.payload_index !== want.payload_index)
                    report("payload_index", want.payload_index, got.payload_index);
                if (got.current_type !== want.current_type)
                    report("current_type", want.current_type, got.current_type);
                if (got.packet_done !== want.packet_done)
                    report("packet_done", want.packet_done, got.packet_done);
            end
        end
    end

    initial
    begin : receiver
        int held;
        held = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                held = HOLD_CYCLES;
            end
            if (held > 0)
            begin
                out_stall <= 1'b1;
                held--;
            end
            else if (calm)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    initial
    begin : stimulus
        cfg_t       c;
        logic [3:0] lo;
        logic [3:0] hi;
        int         phase;
        int         random_start;
        int         phase_end;

        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= CFG_LOWEST_TYPE;
        cfg_data <= '0;
        in_valid <= 1'b0;
        operation <= OP_START;
        rx_byte <= '0;

        cfg_m = '{lowest_type: 4'd1, highest_type: 4'd15, big_threshold: 8'd32,
                  lengths_low: '0, lengths_high: '0};
        pkt_status = ST_EMPTY;
        pkt_type = '0;
        bytes_to_go = '0;
        xor_acc = '0;
        pay_pos = '0;
        big_pending = 1'b0;
        in_transfer = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: bounds 1..15, every length zero
        add_beat(OP_DATA,  8'hFF, 1'b1, ST_EMPTY, 4'd0, 1'b0);  // data before any start
        add_beat(OP_START, 8'h00, 1'b1, ST_EMPTY, 4'd0, 1'b0);
        add_beat(OP_DATA,  8'h00, 1'b1, ST_ERR,   4'd0, 1'b0);  // type zero
        add_beat(OP_DATA,  8'h55, 1'b1, ST_ERR,   4'd0, 1'b0);  // byte after error
        add_beat(OP_START, 8'h3C, 1'b1, ST_EMPTY, 4'd0, 1'b0);
        add_beat(OP_DATA,  8'h10, 1'b1, ST_ERR,   4'd0, 1'b0);  // type past the table
        add_beat(OP_START, 8'h00, 1'b1, ST_EMPTY, 4'd0, 1'b0);
        add_beat(OP_DATA,  8'h03, 1'b1, ST_EMPTY, 4'd3, 1'b0);  // empty payload
        add_beat(OP_DATA,  8'h03, 1'b1, ST_DONE,  4'd3, 1'b1);  // checksum is the type
        add_beat(OP_DATA,  8'hAA, 1'b1, ST_ERR,   4'd3, 1'b0);  // byte after completion
        add_beat(OP_START, 8'hFF, 1'b1, ST_EMPTY, 4'd0, 1'b0);
        add_beat(OP_DATA,  8'h07, 1'b1, ST_EMPTY, 4'd7, 1'b0);
        add_beat(OP_DATA,  8'h00, 1'b1, ST_ERR,   4'd7, 1'b1);  // bad checksum
        add_write(CFG_LOWEST_TYPE, 64'd2);
        add_write(CFG_HIGHEST_TYPE, 64'd14);
        add_write(CFG_BIG_THRESH, 64'd0);
        add_write(CFG_LENGTHS_LOW, 64'h0000_0000_0002_0000);
        add_write(CFG_LENGTHS_HIGH, 64'hFF00_0000_0000_0000);
        add_beat(OP_START, 8'h00, 1'b1, ST_EMPTY, 4'd0, 1'b0);
        add_beat(OP_DATA,  8'h01, 1'b1, ST_ERR,   4'd0, 1'b0);  // below lowest
        add_beat(OP_START, 8'h00, 1'b1, ST_EMPTY, 4'd0, 1'b0);
        add_beat(OP_DATA,  8'h0F, 1'b1, ST_ERR,   4'd0, 1'b0);  // above highest
        // big packet split across two transfers
        add_beat(OP_START, 8'h00, 1'b0, ST_EMPTY, 4'd0, 1'b0);
        add_beat(OP_DATA,  8'h02, 1'b0, ST_EMPTY, 4'd0, 1'b0);
        add_beat(OP_DATA,  8'hA5, 1'b0, ST_EMPTY, 4'd0, 1'b0);
        add_beat(OP_START, 8'h00, 1'b0, ST_EMPTY, 4'd0, 1'b0);
        add_beat(OP_DATA,  8'h5A, 1'b0, ST_EMPTY, 4'd0, 1'b0);
        add_beat(OP_DATA,  8'hFD, 1'b0, ST_EMPTY, 4'd0, 1'b0);
        add_write(CFG_LOWEST_TYPE, 64'd14);                      // inverted bounds
        add_write(CFG_HIGHEST_TYPE, 64'd2);
        add_beat(OP_START, 8'h00, 1'b1, ST_EMPTY, 4'd0, 1'b0);
        add_beat(OP_DATA,  8'h05, 1'b1, ST_ERR,   4'd0, 1'b0);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                drain();
                write_reg(directed_rows[i].idx, directed_rows[i].val);
                if (i + 1 == directed_rows.size() || directed_rows[i + 1].kind != ROW_WRITE)
                    cfg_we <= 1'b0;
            end
            else
                send_beat(directed_rows[i].op, directed_rows[i].data,
                          directed_rows[i].pinned, directed_rows[i].want);
        end

        phase = 0;
        random_start = beats_sent;
        while (beats_sent - random_start < RANDOM_BEATS)
        begin
            drain();
            c = '0;
            for (int k = 0; k < 8; k++)
            begin
                c.lengths_low[k * 8 +: 8] = 8'($urandom_range(0, 12));
                c.lengths_high[k * 8 +: 8] = 8'($urandom_range(0, 12));
            end
            case (phase)
                0:
                begin
                    c.lowest_type = 4'd1;
                    c.highest_type = 4'd15;
                    c.big_threshold = 8'd255;
                end
                1:
                begin
                    // only type 15, full length, always big
                    c.lowest_type = 4'd15;
                    c.highest_type = 4'd15;
                    c.big_threshold = 8'd0;
                    c.lengths_low = '0;
                    c.lengths_high = '1;
                end
                default:
                begin
                    lo = 4'($urandom_range(1, 15));
                    hi = 4'($urandom_range(1, 15));
                    if (lo > hi && $urandom_range(0, 4) != 0)
                    begin
                        c.lowest_type = hi;
                        c.highest_type = lo;
                    end
                    else
                    begin
                        c.lowest_type = lo;
                        c.highest_type = hi;
                    end
                    case ($urandom_range(0, 3))
                        0:       c.big_threshold = 8'd0;
                        1:       c.big_threshold = 8'd255;
                        default: c.big_threshold = 8'($urandom_range(0, 12));
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        c.lengths_low = {$urandom, $urandom};
                end
            endcase
            write_reg(CFG_LOWEST_TYPE, 64'(c.lowest_type));
            write_reg(CFG_HIGHEST_TYPE, 64'(c.highest_type));
            write_reg(CFG_BIG_THRESH, 64'(c.big_threshold));
            write_reg(CFG_LENGTHS_LOW, c.lengths_low);
            write_reg(CFG_LENGTHS_HIGH, c.lengths_high);
            cfg_we <= 1'b0;

            // the long packet phase runs without gaps and with one long output hold
            calm = (phase == 1);
            if (phase == 1)
                hold_pending = 1'b1;

            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_noise($urandom_range(1, 4));
                else
                    send_packet();
            end
            phase++;
        end

        calm = 1'b0;
        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tpdx_pkg.sv
rtl/tpdx_cfg_regs.sv
rtl/tpdx_parser.sv
rtl/typed_packet_deframer_xor_check.sv
dv/tb_typed_packet_deframer_xor_check.sv
